/* hdl/tkp_pkg.sv */
// Package for the per-window top-K peak picker.
// Holds the constants and the transaction structs; used by top_k_peaks_per_window.
package tkp_pkg;

    localparam int NUM_WINDOWS    = 16;
    localparam int MAX_PER_WINDOW = 4;
    localparam int STORE_SIZE     = 64;

    localparam int MASS_W = 28;
    localparam int INT_W  = 32;
    localparam int WIN_W  = 5;
    localparam int PPI_W  = 3;
    localparam int ADDR_W = $clog2(STORE_SIZE);
    localparam int WSEL_W = $clog2(NUM_WINDOWS);
    localparam int SLOT_W = $clog2(MAX_PER_WINDOW);
    localparam int FILL_W = 3;

    localparam logic [PPI_W-1:0] PPI_RESET = 3'd4;

    typedef struct packed {
        logic [MASS_W-1:0] peak_mass;
        logic [INT_W-1:0]  peak_intensity;
        logic [WIN_W-1:0]  window;
        logic              final_peak;
    } t_peak;

    typedef struct packed {
        logic [MASS_W-1:0] kept_mass;
        logic [INT_W-1:0]  kept_intensity;
        logic              last_kept;
    } t_kept;

endpackage

/* hdl/top_k_peaks_per_window.sv */
// Per-window top-K peak picker with a mass-sorted flush on the final peak.
// Depends on tkp_pkg for constants and the peak and result structs.
// Flow: a peak into a window with room is written straight into its slot; a full window
// reads its q slots through the single read port, passes a wait state, then makes q sorted writes.
// A final peak then runs one store pass per emitted result, or one pass if none;
// results are one-cycle strobes that cannot be stalled. Reset clears the store, register 4.
module top_k_peaks_per_window (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  tkp_pkg::t_peak i_peak,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [tkp_pkg::PPI_W-1:0] i_cfg_data,
    output logic          o_result_valid,
    output tkp_pkg::t_kept o_kept
);
    import tkp_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;

    localparam int KEY_W = MASS_W + ADDR_W;

    // Store memory and its per-entry valid bits.
    logic [MASS_W+INT_W-1:0] mem [STORE_SIZE];
    logic [STORE_SIZE-1:0]   r_vbits;
    logic [FILL_W-1:0]       r_fill [NUM_WINDOWS];

    logic [2:0]              r_state;
    logic [PPI_W-1:0]        r_ppi;
    t_peak                   r_item;
    logic [ADDR_W-1:0]       r_base;
    logic [2:0]              r_cnt;
    logic [ADDR_W:0]         r_ptr;
    logic                    r_pv;
    logic [ADDR_W-1:0]       r_pidx;
    logic [MASS_W+INT_W-1:0] r_rd_data;
    logic                    r_rd_vbit;
    logic [MASS_W-1:0]       r_wm [MAX_PER_WINDOW];
    logic [INT_W-1:0]        r_wi [MAX_PER_WINDOW];
    logic                    r_have_prev;
    logic [KEY_W-1:0]        r_prev_key;
    logic                    r_found;
    logic [KEY_W-1:0]        r_best_key;
    logic [INT_W-1:0]        r_best_int;
    logic [1:0]              r_ncand;
    logic                    r_out_vld;
    t_kept                   r_out;

    logic [2:0]              q_eff;
    logic                    win_ok;
    logic [WSEL_W-1:0]       win_sel;
    logic [6:0]              base_full;
    logic [ADDR_W-1:0]       base_addr;
    logic [FILL_W-1:0]       cur_fill;
    logic                    accept;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [MASS_W+INT_W-1:0] wr_data;
    logic [ADDR_W-1:0]       rd_addr;
    logic [MASS_W-1:0]       rd_mass;
    logic [INT_W-1:0]        rd_int;
    logic [1:0]              rank [MAX_PER_WINDOW];
    logic [MASS_W-1:0]       sm [MAX_PER_WINDOW];
    logic [INT_W-1:0]        si [MAX_PER_WINDOW];
    logic                    cand;
    logic [KEY_W-1:0]        cand_key;
    logic                    pass_end;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign o_result_valid = r_out_vld;
    assign o_kept      = r_out;

    // Effective slot count per window, clamped to 1..MAX_PER_WINDOW.
    always_comb begin
        if (r_ppi == '0) begin
            q_eff = 3'd1;
        end else if (r_ppi > 3'(MAX_PER_WINDOW)) begin
            q_eff = 3'(MAX_PER_WINDOW);
        end else begin
            q_eff = r_ppi;
        end
    end

    // Window decode for the incoming peak.
    assign win_ok    = (i_peak.window >= 5'd1) && (i_peak.window <= 5'(NUM_WINDOWS));
    assign win_sel   = WSEL_W'(i_peak.window - 5'd1);
    assign base_full = 7'(win_sel) * 7'(q_eff);
    assign base_addr = base_full[ADDR_W-1:0];
    assign cur_fill  = r_fill[win_sel];

    // Read data as seen by the logic: entries never written read as zero.
    assign rd_mass = r_rd_vbit ? r_rd_data[MASS_W+INT_W-1:INT_W] : '0;
    assign rd_int  = r_rd_vbit ? r_rd_data[INT_W-1:0] : '0;

    // Stable ascending-intensity ranks of the captured window slots.
    always_comb begin
        for (int i = 0; i < MAX_PER_WINDOW; i++) begin
            rank[i] = '0;
            for (int j = 0; j < MAX_PER_WINDOW; j++) begin
                if (j != i && 3'(j) < q_eff &&
                    ((r_wi[j] < r_wi[i]) || (r_wi[j] == r_wi[i] && j < i))) begin
                    rank[i] = rank[i] + 2'd1;
                end
            end
        end
        for (int k = 0; k < MAX_PER_WINDOW; k++) begin
            sm[k] = '0;
            si[k] = '0;
        end
        for (int i = 0; i < MAX_PER_WINDOW; i++) begin
            if (3'(i) < q_eff) begin
                sm[rank[i]] = r_wm[i];
                si[rank[i]] = r_wi[i];
            end
        end
    end

    // Memory write port: direct insert from idle, or sorted write-back.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (r_state == S_IDLE) begin
            wr_en   = accept && win_ok && (cur_fill < q_eff);
            wr_addr = base_addr + ADDR_W'(cur_fill);
            wr_data = {i_peak.peak_mass, i_peak.peak_intensity};
        end else if (r_state == S_WR) begin
            wr_en   = 1'b1;
            wr_addr = r_base + ADDR_W'(r_cnt);
            if (r_cnt == '0 && r_item.peak_intensity > si[0]) begin
                wr_data = {r_item.peak_mass, r_item.peak_intensity};
            end else begin
                wr_data = {sm[r_cnt[SLOT_W-1:0]], si[r_cnt[SLOT_W-1:0]]};
            end
        end
    end

    // Memory read address: window slots, or the scan pointer.
    always_comb begin
        if (r_state == S_RD) begin
            rd_addr = r_base + ADDR_W'(r_cnt);
        end else begin
            rd_addr = r_ptr[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
        r_rd_vbit <= r_vbits[rd_addr];
    end

    // Scan candidate: stored, nonzero mass, and above the last emitted key.
    assign cand_key = {rd_mass, r_pidx};
    assign cand     = r_pv && (rd_mass != '0) && (!r_have_prev || cand_key > r_prev_key);
    assign pass_end = (r_state == S_SCAN) && r_ptr[ADDR_W] && !r_pv;

    // Control sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ppi       <= PPI_RESET;
            r_vbits     <= '0;
            r_pv        <= 1'b0;
            r_out_vld   <= 1'b0;
            r_have_prev <= 1'b0;
            r_found     <= 1'b0;
            r_ncand     <= '0;
            r_ptr       <= '0;
            r_cnt       <= '0;
            for (int w = 0; w < NUM_WINDOWS; w++) begin
                r_fill[w] <= '0;
            end
        end else begin
            r_out_vld <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_ppi <= i_cfg_data;
            end
            if (wr_en) begin
                r_vbits[wr_addr] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_item <= i_peak;
                        r_base <= base_addr;
                        r_cnt  <= '0;
                        r_ptr  <= '0;
                        r_pv   <= 1'b0;
                        r_have_prev <= 1'b0;
                        r_found <= 1'b0;
                        r_ncand <= '0;
                        if (win_ok && cur_fill < q_eff) begin
                            r_fill[win_sel] <= cur_fill + 3'd1;
                            r_state <= i_peak.final_peak ? S_SCAN : S_IDLE;
                        end else if (win_ok) begin
                            r_state <= S_RD;
                        end else begin
                            r_state <= i_peak.final_peak ? S_SCAN : S_IDLE;
                        end
                    end
                end
                S_RD: begin
                    r_pv   <= 1'b1;
                    r_pidx <= ADDR_W'(r_cnt);
                    if (r_cnt == q_eff - 3'd1) begin
                        r_cnt   <= '0;
                        r_state <= S_WAIT;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_WAIT: begin
                    r_pv    <= 1'b0;
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (r_cnt == q_eff - 3'd1) begin
                        r_cnt   <= '0;
                        r_state <= r_item.final_peak ? S_SCAN : S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_SCAN: begin
                    if (pass_end) begin
                        r_ptr   <= '0;
                        r_found <= 1'b0;
                        r_ncand <= '0;
                        if (r_found) begin
                            r_out_vld <= 1'b1;
                            r_out.kept_mass      <= r_best_key[KEY_W-1:ADDR_W];
                            r_out.kept_intensity <= r_best_int;
                            r_out.last_kept      <= (r_ncand == 2'd1);
                            r_have_prev <= 1'b1;
                            r_prev_key  <= r_best_key;
                        end
                        if (!r_found || r_ncand == 2'd1) begin
                            r_state <= S_IDLE;
                            r_vbits <= '0;
                            for (int w = 0; w < NUM_WINDOWS; w++) begin
                                r_fill[w] <= '0;
                            end
                        end
                    end else begin
                        r_pv   <= !r_ptr[ADDR_W];
                        r_pidx <= r_ptr[ADDR_W-1:0];
                        if (!r_ptr[ADDR_W]) begin
                            r_ptr <= r_ptr + (ADDR_W+1)'(1);
                        end
                        if (cand) begin
                            if (r_ncand != 2'd2) begin
                                r_ncand <= r_ncand + 2'd1;
                            end
                            if (!r_found || cand_key < r_best_key) begin
                                r_found    <= 1'b1;
                                r_best_key <= cand_key;
                                r_best_int <= rd_int;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Capture of the window slots while they are read back.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_RD || r_state == S_WAIT) && r_pv) begin
            r_wm[r_pidx[SLOT_W-1:0]] <= rd_mass;
            r_wi[r_pidx[SLOT_W-1:0]] <= rd_int;
        end
    end

    // A result only follows the end of a store pass.
    a_out_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state) == S_SCAN)
        else $error("result strobe outside a store pass");

    // The last result of a flush leaves the store empty and the block idle.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_kept.last_kept) |-> (r_state == S_IDLE && r_vbits == '0))
        else $error("store not cleared after final result");

    // Write-back never runs past the window's slot count.
    a_wr_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> (r_cnt < q_eff))
        else $error("write-back beyond window");

    // A new transaction is only taken while idle.
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_IDLE || r_state == S_RD || r_state == S_SCAN))
        else $error("unexpected state after accept");

endmodule
